// File: rtl/sparse_set_row_table_assert.svh
// Assertion macros for the sparse-set row table core.
`ifndef SPARSE_SET_ROW_TABLE_ASSERT_SVH
`define SPARSE_SET_ROW_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sparse set row table check failed");

// Next-cycle implication, checked out of reset.
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sparse set row table check failed");

`endif

// File: rtl/sst_pkg.sv
`default_nettype none
package sst_pkg;

  localparam int ROWS        = 16;
  localparam int COLUMNS     = 64;   // power of two: row and column concatenate to an address
  localparam int VALUE_WIDTH = 32;

  localparam int OPC_W   = 3;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int CNT_W   = $clog2(COLUMNS + 1);
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int DENSE_W = COL_W + VALUE_WIDTH;

  // Map entry of an absent column, one past the last dense position
  localparam logic [CNT_W-1:0] ABSENT_POS = CNT_W'(COLUMNS);

  typedef enum logic [OPC_W-1:0] {
    OP_LOOKUP    = 3'd0,
    OP_EMPLACE   = 3'd1,
    OP_ERASE     = 3'd2,
    OP_CLR_ROW   = 3'd3,
    OP_CLR_ALL   = 3'd4,
    OP_READ_POS  = 3'd5,
    OP_OVERWRITE = 3'd6
  } op_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  data;
  } map_wr_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [DENSE_W-1:0] data;
  } dense_wr_t;

endpackage
`default_nettype wire

// File: rtl/sst_ram.sv
`default_nettype none
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/sst_core.sv
`default_nettype none
module sst_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [sst_pkg::OPC_W-1:0]           opcode_i,
  input  wire logic [sst_pkg::ROW_W-1:0]           row_sel_i,
  input  wire logic [sst_pkg::COL_W-1:0]           column_i,
  input  wire logic [sst_pkg::COL_W-1:0]           position_i,
  input  wire logic [sst_pkg::VALUE_WIDTH-1:0]     value_in_i,
  output logic                                     busy_o,
  output logic                                     done_o,
  output logic                                     found_o,
  output logic      [sst_pkg::VALUE_WIDTH-1:0]     value_out_o,
  output logic      [sst_pkg::COL_W-1:0]           column_out_o,
  output logic      [sst_pkg::CNT_W-1:0]           row_count_o,
  output sst_pkg::map_wr_t                         map_wr_o,
  output logic      [sst_pkg::ADDR_W-1:0]          map_raddr_o,
  input  wire logic [sst_pkg::CNT_W-1:0]           map_rdata_i,
  output sst_pkg::dense_wr_t                       dense_wr_o,
  output logic      [sst_pkg::ADDR_W-1:0]          dense_raddr_o,
  input  wire logic [sst_pkg::DENSE_W-1:0]         dense_rdata_i
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MAP,
    S_CHK,
    S_LAST,
    S_POS
  } state_e;

  state_e                            state_q, state_d;
  logic [sst_pkg::ADDR_W-1:0]        init_q, init_d;
  sst_pkg::op_e                      op_q, op_d;
  logic [sst_pkg::ROW_W-1:0]         row_q, row_d;
  logic [sst_pkg::COL_W-1:0]         col_q, col_d;
  logic [sst_pkg::COL_W-1:0]         pos_q, pos_d;
  logic [sst_pkg::VALUE_WIDTH-1:0]   val_q, val_d;
  logic [sst_pkg::CNT_W-1:0]         p_q, p_d;
  logic [sst_pkg::CNT_W-1:0]         counts_q [sst_pkg::ROWS];
  logic [sst_pkg::CNT_W-1:0]         counts_d [sst_pkg::ROWS];
  logic                              done_q, done_d;
  logic                              found_q, found_d;
  logic [sst_pkg::VALUE_WIDTH-1:0]   value_q, value_d;
  logic [sst_pkg::COL_W-1:0]         column_q, column_d;
  logic [sst_pkg::CNT_W-1:0]         count_q, count_d;

  logic                              accept;
  sst_pkg::op_e                      op_in;
  logic [sst_pkg::CNT_W-1:0]         cnt_cur;
  logic [sst_pkg::CNT_W-1:0]         cnt_last;
  logic [sst_pkg::COL_W-1:0]         rd_col;
  logic [sst_pkg::VALUE_WIDTH-1:0]   rd_val;
  logic                              hit;

  assign accept  = start_i && (state_q == S_IDLE);
  assign op_in   = sst_pkg::op_e'(opcode_i);
  assign busy_o  = (state_q != S_IDLE);
  assign cnt_cur = counts_q[row_q];
  assign cnt_last = cnt_cur - sst_pkg::CNT_W'(1);
  assign rd_col  = dense_rdata_i[sst_pkg::DENSE_W-1 -: sst_pkg::COL_W];
  assign rd_val  = dense_rdata_i[sst_pkg::VALUE_WIDTH-1:0];

  // Shared compare: position inside the dense list and pointing back at the column
  assign hit = (p_q < cnt_cur) && (rd_col == col_q);

  // Sequencer and datapath next values
  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    op_d     = op_q;
    row_d    = row_q;
    col_d    = col_q;
    pos_d    = pos_q;
    val_d    = val_q;
    p_d      = p_q;
    counts_d = counts_q;
    done_d   = 1'b0;
    found_d  = found_q;
    value_d  = value_q;
    column_d = column_q;
    count_d  = count_q;

    map_wr_o      = '0;
    map_raddr_o   = {row_sel_i, column_i};
    dense_wr_o    = '0;
    dense_raddr_o = {row_sel_i, position_i};

    case (state_q)
      S_INIT: begin
        // Sweep every map entry to the absent marker
        map_wr_o.we   = 1'b1;
        map_wr_o.addr = init_q;
        map_wr_o.data = sst_pkg::ABSENT_POS;
        init_d        = init_q + sst_pkg::ADDR_W'(1);
        if (init_q == {sst_pkg::ADDR_W{1'b1}}) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          op_d     = op_in;
          row_d    = row_sel_i;
          col_d    = column_i;
          pos_d    = position_i;
          val_d    = value_in_i;
          found_d  = 1'b0;
          value_d  = '0;
          column_d = '0;
          case (op_in)
            sst_pkg::OP_LOOKUP, sst_pkg::OP_EMPLACE, sst_pkg::OP_ERASE,
            sst_pkg::OP_OVERWRITE: begin
              state_d = S_MAP;
            end
            sst_pkg::OP_READ_POS: begin
              state_d = S_POS;
            end
            sst_pkg::OP_CLR_ROW: begin
              counts_d[row_sel_i] = '0;
              count_d = '0;
              done_d  = 1'b1;
            end
            sst_pkg::OP_CLR_ALL: begin
              for (int i = 0; i < sst_pkg::ROWS; i++) begin
                counts_d[i] = '0;
              end
              count_d = '0;
              done_d  = 1'b1;
            end
            default: begin
              count_d = counts_q[row_sel_i];
              done_d  = 1'b1;
            end
          endcase
        end
      end

      S_MAP: begin
        // Follow the map entry into the dense list
        p_d           = map_rdata_i;
        dense_raddr_o = {row_q, map_rdata_i[sst_pkg::COL_W-1:0]};
        state_d       = S_CHK;
      end

      S_CHK: begin
        found_d = hit;
        count_d = cnt_cur;
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (op_q)
          sst_pkg::OP_LOOKUP: begin
            value_d = hit ? rd_val : '0;
          end
          sst_pkg::OP_EMPLACE, sst_pkg::OP_OVERWRITE: begin
            if (hit) begin
              if (op_q == sst_pkg::OP_OVERWRITE) begin
                dense_wr_o.we   = 1'b1;
                dense_wr_o.addr = {row_q, p_q[sst_pkg::COL_W-1:0]};
                dense_wr_o.data = {col_q, val_q};
                value_d         = val_q;
              end else begin
                value_d = rd_val;
              end
            end else if (cnt_cur < sst_pkg::ABSENT_POS) begin
              // Append at the dense end
              map_wr_o.we     = 1'b1;
              map_wr_o.addr   = {row_q, col_q};
              map_wr_o.data   = cnt_cur;
              dense_wr_o.we   = 1'b1;
              dense_wr_o.addr = {row_q, cnt_cur[sst_pkg::COL_W-1:0]};
              dense_wr_o.data = {col_q, val_q};
              counts_d[row_q] = cnt_cur + sst_pkg::CNT_W'(1);
              count_d         = cnt_cur + sst_pkg::CNT_W'(1);
              value_d         = val_q;
            end
          end
          sst_pkg::OP_ERASE: begin
            value_d = '0;
            if (hit) begin
              // Fetch the last dense entry to fill the gap
              dense_raddr_o = {row_q, cnt_last[sst_pkg::COL_W-1:0]};
              state_d       = S_LAST;
              done_d        = 1'b0;
            end
          end
          default: begin
            value_d = '0;
          end
        endcase
      end

      S_LAST: begin
        // Move the last entry into the erased slot, unless it is the erased entry, and drop the count
        if (rd_col != col_q) begin
          dense_wr_o.we   = 1'b1;
          dense_wr_o.addr = {row_q, p_q[sst_pkg::COL_W-1:0]};
          dense_wr_o.data = dense_rdata_i;
          map_wr_o.we     = 1'b1;
          map_wr_o.addr   = {row_q, rd_col};
          map_wr_o.data   = p_q;
        end
        counts_d[row_q] = cnt_last;
        count_d         = cnt_last;
        found_d         = 1'b1;
        value_d         = '0;
        state_d         = S_IDLE;
        done_d          = 1'b1;
      end

      S_POS: begin
        found_d  = ({1'b0, pos_q} < cnt_cur);
        value_d  = found_d ? rd_val : '0;
        column_d = found_d ? rd_col : '0;
        count_d  = cnt_cur;
        state_d  = S_IDLE;
        done_d   = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, counts and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      init_q   <= '0;
      op_q     <= sst_pkg::OP_LOOKUP;
      row_q    <= '0;
      col_q    <= '0;
      pos_q    <= '0;
      val_q    <= '0;
      p_q      <= '0;
      for (int i = 0; i < sst_pkg::ROWS; i++) begin
        counts_q[i] <= '0;
      end
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      value_q  <= '0;
      column_q <= '0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      op_q     <= op_d;
      row_q    <= row_d;
      col_q    <= col_d;
      pos_q    <= pos_d;
      val_q    <= val_d;
      p_q      <= p_d;
      counts_q <= counts_d;
      done_q   <= done_d;
      found_q  <= found_d;
      value_q  <= value_d;
      column_q <= column_d;
      count_q  <= count_d;
    end
  end

  assign done_o       = done_q;
  assign found_o      = found_q;
  assign value_out_o  = value_q;
  assign column_out_o = column_q;
  assign row_count_o  = count_q;

`include "sparse_set_row_table_assert.svh"

  `SST_ASSERT_IMP(a_count_range, clk_i, rst_ni, done_q, count_q <= sst_pkg::ABSENT_POS)
  `SST_ASSERT_IMP(a_lookup_latency, clk_i, rst_ni, accept && (op_in == sst_pkg::OP_LOOKUP), ##3 done_q)
  `SST_ASSERT_IMP(a_erase_no_value, clk_i, rst_ni, done_q && (op_q == sst_pkg::OP_ERASE), value_q == '0)
  `SST_ASSERT_IMP(a_miss_no_column, clk_i, rst_ni, done_q && !found_q, column_q == '0)
  `SST_ASSERT_NXT(a_init_quiet, clk_i, rst_ni, state_q == S_INIT, !done_q)

endmodule
`default_nettype wire

// File: rtl/sparse_set_row_table.sv
`default_nettype none
// Sparse-set row table: 16 rows, each a set of column/value entries over 64 columns.
// Drive start_i with an operation on opcode_i, row_sel_i, column_i, position_i and
// value_in_i; the item is taken at a clock edge where start_i is high and busy_o low.
// Each item gives one result, shown for one cycle with done_o high on found_o,
// value_out_o, column_out_o and row_count_o. The receiver cannot stall the block.
// Steps of each item from acceptance up to the strobe, in whose cycle the next item can be taken:
//   clear row, clear all, unused opcode: the result is set at acceptance
//   read position: one registered dense-list read
//   lookup, emplace, overwrite, erase of an absent column: map read, then dense read
//   erase of a present column: adds a read of the last dense entry
// The count of each row lives in flip-flops, so clears write no RAM entry. Membership is
// confirmed when the mapped position is below the row count and its dense entry points
// back at the column. After reset the block sweeps all 1024 column map entries, one
// entry a cycle, with busy_o high, before it takes the first item.
module sparse_set_row_table (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [sst_pkg::OPC_W-1:0]         opcode_i,
  input  wire logic [sst_pkg::ROW_W-1:0]         row_sel_i,
  input  wire logic [sst_pkg::COL_W-1:0]         column_i,
  input  wire logic [sst_pkg::COL_W-1:0]         position_i,
  input  wire logic [sst_pkg::VALUE_WIDTH-1:0]   value_in_i,
  output logic                                   done_o,
  output logic                                   found_o,
  output logic      [sst_pkg::VALUE_WIDTH-1:0]   value_out_o,
  output logic      [sst_pkg::COL_W-1:0]         column_out_o,
  output logic      [sst_pkg::CNT_W-1:0]         row_count_o
);

  sst_pkg::map_wr_t                 map_wr;
  sst_pkg::dense_wr_t               dense_wr;
  logic [sst_pkg::ADDR_W-1:0]       map_raddr;
  logic [sst_pkg::ADDR_W-1:0]       dense_raddr;
  logic [sst_pkg::CNT_W-1:0]        map_rdata;
  logic [sst_pkg::DENSE_W-1:0]      dense_rdata;

  // Column to dense position map
  sst_ram #(
    .WIDTH (sst_pkg::CNT_W),
    .DEPTH (sst_pkg::CELLS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_wr.we),
    .waddr_i (map_wr.addr),
    .wdata_i (map_wr.data),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // Dense list of column and value per position
  sst_ram #(
    .WIDTH (sst_pkg::DENSE_W),
    .DEPTH (sst_pkg::CELLS)
  ) u_dense_ram (
    .clk_i   (clk_i),
    .we_i    (dense_wr.we),
    .waddr_i (dense_wr.addr),
    .wdata_i (dense_wr.data),
    .raddr_i (dense_raddr),
    .rdata_o (dense_rdata)
  );

  // Sequencer and compare unit
  sst_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .opcode_i      (opcode_i),
    .row_sel_i     (row_sel_i),
    .column_i      (column_i),
    .position_i    (position_i),
    .value_in_i    (value_in_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .found_o       (found_o),
    .value_out_o   (value_out_o),
    .column_out_o  (column_out_o),
    .row_count_o   (row_count_o),
    .map_wr_o      (map_wr),
    .map_raddr_o   (map_raddr),
    .map_rdata_i   (map_rdata),
    .dense_wr_o    (dense_wr),
    .dense_raddr_o (dense_raddr),
    .dense_rdata_i (dense_rdata)
  );

endmodule
`default_nettype wire
